### hw/rtl/brcs_pkg.sv
// bell ring cadence sequencer: shared types, codes and reset constants
// used by every rtl file of the block; depends on nothing
`default_nettype none

package brcs_pkg;

  // request function codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_START   = 2'd1;
  localparam logic [1:0] FUNC_HANDSET = 2'd2;

  // ring steps
  localparam logic [2:0] STEP_C1_ON  = 3'd0;
  localparam logic [2:0] STEP_C1_OFF = 3'd1;
  localparam logic [2:0] STEP_C2_ON  = 3'd2;
  localparam logic [2:0] STEP_C2_OFF = 3'd3;
  localparam logic [2:0] STEP_SHORT  = 3'd4;
  localparam logic [2:0] STEP_LONG   = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_TIME       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PAUSE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PAUSE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RINGS_PER_BURST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVE_UP_RINGS   = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [7:0]  COIL_TIME_RST       = 8'd17;
  localparam logic [15:0] SHORT_PAUSE_RST     = 16'd400;
  localparam logic [15:0] LONG_PAUSE_RST      = 16'd1600;
  localparam logic [3:0]  RINGS_PER_BURST_RST = 4'd4;
  localparam logic [7:0]  GIVE_UP_RINGS_RST   = 8'd50;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RINGING = 2'd1,
    MODE_PLAYING = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] func;
    logic       handset_down;
  } in_item_t;

  typedef struct packed {
    logic coil_one;
    logic coil_two;
    logic ringing;
    logic playing;
    logic gave_up;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  coil_time;
    logic [15:0] short_pause;
    logic [15:0] long_pause;
    logic [3:0]  rings_per_burst;
    logic [7:0]  give_up_rings;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  ring_step;
    logic [15:0] step_ticks;
    logic [3:0]  rings_in_burst;
    logic        long_pause_next;
    logic [7:0]  rings_total;
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/bell_ring_cadence_sequencer_core.sv
// bell ring cadence sequencer, top level: request register, state and result register
// depends on brcs_pkg, brcs_cfg_regs and brcs_next_state
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   in_data  (func, handset_down)
//   out      source     out_valid / out_ready out_data (coils, ringing, playing, gave_up)
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// one result per request; a request is taken into the request register, and
// once the result register is free or being emptied it updates the state and
// lands in the result register (one request per cycle sustained while results are taken)
// the result register and the request register together hold two requests, so a
// stalled result still lets one more request in
// rst is synchronous: mode idle, all counters cleared, registers at their defaults
`default_nettype none

module bell_ring_cadence_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire brcs_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output brcs_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [brcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  brcs_pkg::cfg_t      cfg;
  brcs_pkg::state_t    state;
  brcs_pkg::state_t    state_next;
  brcs_pkg::in_item_t  hold;
  brcs_pkg::out_item_t result;
  logic                hold_valid;
  logic                advance;

  brcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brcs_next_state u_next (
    .st      (state),
    .cfg     (cfg),
    .item    (hold),
    .st_next (state_next),
    .result  (result)
  );

  // held request moves on when the result register is free or being emptied
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

  // sequencer state, updated once per request as it moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= brcs_pkg::MODE_IDLE;
      state.ring_step       <= brcs_pkg::STEP_C1_ON;
      state.step_ticks      <= '0;
      state.rings_in_burst  <= '0;
      state.long_pause_next <= 1'b1;
      state.rings_total     <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // a moved request always leaves a result behind
  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after a request moved");

  // the coils never drive together
  a_coils_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.coil_one && out_data.coil_two))
    else $error("both coils driven");

  // a coil only drives while ringing, and ringing excludes playing
  a_coil_ringing: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.coil_one || out_data.coil_two) |->
      out_data.ringing && !out_data.playing)
    else $error("coil driven outside ringing");

  // giving up ends ringing on the same result
  a_gave_up_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gave_up |-> !out_data.ringing && !out_data.playing)
    else $error("gave up while still active");

endmodule

`default_nettype wire

### hw/rtl/brcs_cfg_regs.sv
// bell ring cadence sequencer: configuration register file
// depends on brcs_pkg
`default_nettype none

module brcs_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [brcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [brcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output brcs_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coil_time       <= brcs_pkg::COIL_TIME_RST;
      cfg.short_pause     <= brcs_pkg::SHORT_PAUSE_RST;
      cfg.long_pause      <= brcs_pkg::LONG_PAUSE_RST;
      cfg.rings_per_burst <= brcs_pkg::RINGS_PER_BURST_RST;
      cfg.give_up_rings   <= brcs_pkg::GIVE_UP_RINGS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brcs_pkg::CFG_COIL_TIME:       cfg.coil_time       <= cfg_data[7:0];
        brcs_pkg::CFG_SHORT_PAUSE:     cfg.short_pause     <= cfg_data[15:0];
        brcs_pkg::CFG_LONG_PAUSE:      cfg.long_pause      <= cfg_data[15:0];
        brcs_pkg::CFG_RINGS_PER_BURST: cfg.rings_per_burst <= cfg_data[3:0];
        brcs_pkg::CFG_GIVE_UP_RINGS:   cfg.give_up_rings   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/brcs_next_state.sv
// bell ring cadence sequencer: next state and result for one request
// purely combinational; depends on brcs_pkg
`default_nettype none

module brcs_next_state (
  input  wire brcs_pkg::state_t    st,
  input  wire brcs_pkg::cfg_t      cfg,
  input  wire brcs_pkg::in_item_t  item,
  output brcs_pkg::state_t         st_next,
  output brcs_pkg::out_item_t      result
);

  logic [2:0]  cur_step;
  logic [2:0]  tgt;
  logic [15:0] ticks_inc;
  logic [15:0] step_len;
  logic [3:0]  rib_inc;
  logic [8:0]  rings_inc;
  logic        gave;
  brcs_pkg::state_t nxt;

  always_comb begin
    nxt       = st;
    gave      = 1'b0;
    cur_step  = (st.ring_step > brcs_pkg::STEP_LONG) ? brcs_pkg::STEP_C1_ON : st.ring_step;
    ticks_inc = st.step_ticks + 16'd1;
    rib_inc   = st.rings_in_burst + 4'd1;
    rings_inc = {1'b0, st.rings_total} + 9'd1;
    tgt       = cur_step;

    priority if (cur_step == brcs_pkg::STEP_SHORT) begin
      step_len = cfg.short_pause;
    end else if (cur_step == brcs_pkg::STEP_LONG) begin
      step_len = cfg.long_pause;
    end else begin
      step_len = {8'd0, (cfg.coil_time == 8'd0) ? 8'd1 : cfg.coil_time};
    end

    unique case (item.func)
      brcs_pkg::FUNC_TICK: begin
        if (st.mode == brcs_pkg::MODE_RINGING) begin
          nxt.ring_step  = cur_step;
          nxt.step_ticks = ticks_inc;
          if (ticks_inc >= step_len) begin
            nxt.step_ticks = '0;
            unique case (cur_step)
              brcs_pkg::STEP_C2_OFF: begin
                nxt.rings_in_burst = rib_inc;
                if (rib_inc == cfg.rings_per_burst) begin
                  // burst over: flip the long pause flag, go to short pause
                  nxt.rings_in_burst  = '0;
                  nxt.long_pause_next = !st.long_pause_next;
                  tgt = brcs_pkg::STEP_SHORT;
                end else begin
                  tgt = brcs_pkg::STEP_C1_ON;
                end
              end
              brcs_pkg::STEP_SHORT: begin
                tgt = nxt.long_pause_next ? brcs_pkg::STEP_C1_ON : brcs_pkg::STEP_LONG;
              end
              brcs_pkg::STEP_LONG: tgt = brcs_pkg::STEP_C1_ON;
              default:             tgt = cur_step + 3'd1;
            endcase
            // zero length pauses are skipped
            if (tgt == brcs_pkg::STEP_SHORT && cfg.short_pause == 16'd0) begin
              tgt = nxt.long_pause_next ? brcs_pkg::STEP_C1_ON : brcs_pkg::STEP_LONG;
            end
            if (tgt == brcs_pkg::STEP_LONG && cfg.long_pause == 16'd0) begin
              tgt = brcs_pkg::STEP_C1_ON;
            end
            nxt.ring_step = tgt;
            // back at coil one on: a ring has finished
            if (tgt == brcs_pkg::STEP_C1_ON) begin
              if (rings_inc > {1'b0, cfg.give_up_rings}) begin
                nxt.mode        = brcs_pkg::MODE_IDLE;
                nxt.rings_total = '0;
                nxt.ring_step   = brcs_pkg::STEP_C1_ON;
                nxt.step_ticks  = '0;
                gave            = 1'b1;
              end else begin
                nxt.rings_total = rings_inc[7:0];
              end
            end
          end
        end
      end
      brcs_pkg::FUNC_START: begin
        nxt.rings_total = '0;
        if (st.mode != brcs_pkg::MODE_RINGING) begin
          nxt.ring_step  = brcs_pkg::STEP_C1_ON;
          nxt.step_ticks = '0;
        end
        nxt.mode = brcs_pkg::MODE_RINGING;
      end
      brcs_pkg::FUNC_HANDSET: begin
        priority if (!item.handset_down && st.mode != brcs_pkg::MODE_PLAYING) begin
          nxt.mode        = brcs_pkg::MODE_PLAYING;
          nxt.rings_total = '0;
        end else if (item.handset_down && st.mode == brcs_pkg::MODE_PLAYING) begin
          nxt.mode        = brcs_pkg::MODE_IDLE;
          nxt.rings_total = '0;
        end else begin
        end
      end
      default: ;
    endcase

    st_next         = nxt;
    result.ringing  = (nxt.mode == brcs_pkg::MODE_RINGING);
    result.playing  = (nxt.mode == brcs_pkg::MODE_PLAYING);
    result.coil_one = result.ringing && (nxt.ring_step == brcs_pkg::STEP_C1_ON);
    result.coil_two = result.ringing && (nxt.ring_step == brcs_pkg::STEP_C2_ON);
    result.gave_up  = gave;
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// testbench for bell_ring_cadence_sequencer_core: directed and random requests checked
// against a cycle-free cadence predictor kept in this file
// depends on brcs_pkg and the rtl of the block
`default_nettype none

module tb_top;
  import brcs_pkg::*;

  // func code 3 has no meaning in the block, it must leave the state alone
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // longest stretch without any handshake before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // long output hold-off used to fill the block up
  localparam int STALL_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // idle percentages of the two sides, changed between test groups
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // a test asks for an output hold-off here, the receiver takes it over
  int stall_len = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  // shadow copy of the block: registers and cadence state
  cfg_t      bell_cfg;
  state_t    bell_st;
  out_item_t pending_bells[$];

  always #4 clk = ~clk;

  bell_ring_cadence_sequencer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // cadence predictor
  // ---------------------------------------------------------------------------

  // a ring is complete; returns 1 when the ring count passes the give-up limit
  function automatic logic count_ring();
    logic [8:0] n;
    n = {1'b0, bell_st.rings_total} + 9'd1;
    if (n > {1'b0, bell_cfg.give_up_rings}) begin
      bell_st.mode        = MODE_IDLE;
      bell_st.rings_total = '0;
      bell_st.ring_step   = STEP_C1_ON;
      bell_st.step_ticks  = '0;
      return 1'b1;
    end
    bell_st.rings_total = n[7:0];
    return 1'b0;
  endfunction

  // move to a step; zero-length pauses are skipped, landing on coil one ends a ring
  function automatic logic begin_step(logic [2:0] s);
    bell_st.step_ticks = '0;
    if (s == STEP_SHORT && bell_cfg.short_pause == 16'd0)
      s = bell_st.long_pause_next ? STEP_C1_ON : STEP_LONG;
    if (s == STEP_LONG && bell_cfg.long_pause == 16'd0)
      s = STEP_C1_ON;
    bell_st.ring_step = s;
    if (s == STEP_C1_ON)
      return count_ring();
    return 1'b0;
  endfunction

  function automatic int unsigned step_len(logic [2:0] s);
    if (s == STEP_SHORT)
      return 32'(bell_cfg.short_pause);
    if (s == STEP_LONG)
      return 32'(bell_cfg.long_pause);
    // a coil time of zero still lasts one tick
    return (bell_cfg.coil_time == 8'd0) ? 32'd1 : 32'(bell_cfg.coil_time);
  endfunction

  // one millisecond while ringing; returns the give-up pulse
  function automatic logic ring_tick();
    if (bell_st.ring_step > STEP_LONG)
      bell_st.ring_step = STEP_C1_ON;
    bell_st.step_ticks = bell_st.step_ticks + 16'd1;
    if (32'(bell_st.step_ticks) < step_len(bell_st.ring_step))
      return 1'b0;
    case (bell_st.ring_step)
      STEP_C2_OFF: begin
        // the burst count wraps at 16 and only ends on an exact match
        bell_st.rings_in_burst = bell_st.rings_in_burst + 4'd1;
        if (bell_st.rings_in_burst == bell_cfg.rings_per_burst) begin
          bell_st.rings_in_burst  = '0;
          bell_st.long_pause_next = ~bell_st.long_pause_next;
          return begin_step(STEP_SHORT);
        end
        return begin_step(STEP_C1_ON);
      end
      // flag already toggled at burst end: low means the long pause follows
      STEP_SHORT: return begin_step(bell_st.long_pause_next ? STEP_C1_ON : STEP_LONG);
      STEP_LONG:  return begin_step(STEP_C1_ON);
      default:    return begin_step(bell_st.ring_step + 3'd1);
    endcase
  endfunction

  // apply one accepted request to the shadow state and return the expected outputs
  function automatic out_item_t predict_bells(in_item_t it);
    logic      gave;
    out_item_t r;
    gave = 1'b0;
    case (it.func)
      FUNC_TICK: begin
        if (bell_st.mode == MODE_RINGING)
          gave = ring_tick();
      end
      FUNC_START: begin
        // start also wins over playing; a running ring keeps its step
        bell_st.rings_total = '0;
        if (bell_st.mode != MODE_RINGING) begin
          bell_st.ring_step  = STEP_C1_ON;
          bell_st.step_ticks = '0;
        end
        bell_st.mode = MODE_RINGING;
      end
      FUNC_HANDSET: begin
        if (!it.handset_down && bell_st.mode != MODE_PLAYING) begin
          bell_st.mode        = MODE_PLAYING;
          bell_st.rings_total = '0;
        end else if (it.handset_down && bell_st.mode == MODE_PLAYING) begin
          bell_st.mode        = MODE_IDLE;
          bell_st.rings_total = '0;
        end
      end
      default: ;
    endcase
    r.coil_one = (bell_st.mode == MODE_RINGING) && (bell_st.ring_step == STEP_C1_ON);
    r.coil_two = (bell_st.mode == MODE_RINGING) && (bell_st.ring_step == STEP_C2_ON);
    r.ringing  = (bell_st.mode == MODE_RINGING);
    r.playing  = (bell_st.mode == MODE_PLAYING);
    r.gave_up  = gave;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random ready, long hold-off on request, field checks
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_len != 0) begin
      stall_left = stall_len;
      stall_len  = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_bells.size() == 0) begin
        $error("result with no request outstanding: %b", out_data);
        mismatches++;
      end else begin
        exp_r = pending_bells.pop_front();
        check_field("coil_one", exp_r.coil_one, out_data.coil_one);
        check_field("coil_two", exp_r.coil_two, out_data.coil_two);
        check_field("ringing",  exp_r.ringing,  out_data.ringing);
        check_field("playing",  exp_r.playing,  out_data.playing);
        check_field("gave_up",  exp_r.gave_up,  out_data.gave_up);
      end
    end
  end

  // hang detection: any handshake on either side clears the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  function automatic in_item_t req(input logic [1:0] func, input logic down);
    in_item_t it;
    it.func         = func;
    it.handset_down = down;
    return it;
  endfunction

  // random request shaped by the predicted mode: mostly ticks while ringing,
  // restarts and handset traffic while idle or playing
  function automatic in_item_t pick_request();
    int   r;
    logic down;
    r    = $urandom_range(99);
    down = 1'($urandom_range(1));
    if (bell_st.mode == MODE_RINGING) begin
      if (r < 88)      return req(FUNC_TICK, down);
      else if (r < 92) return req(FUNC_START, down);
      else if (r < 95) return req(FUNC_HANDSET, 1'b0);
      else if (r < 98) return req(FUNC_HANDSET, 1'b1);
      return req(FUNC_UNUSED, down);
    end
    if (r < 40)      return req(FUNC_START, down);
    else if (r < 60) return req(FUNC_HANDSET, down);
    else if (r < 70) return req(FUNC_UNUSED, down);
    return req(FUNC_TICK, down);
  endfunction

  // offer one request, hold it until taken, then record its expected outputs
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_bells.push_back(predict_bells(it));
  endtask

  // stop offering and wait until every request has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bells.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_COIL_TIME:       bell_cfg.coil_time       = value[7:0];
      CFG_SHORT_PAUSE:     bell_cfg.short_pause     = value;
      CFG_LONG_PAUSE:      bell_cfg.long_pause      = value;
      CFG_RINGS_PER_BURST: bell_cfg.rings_per_burst = value[3:0];
      CFG_GIVE_UP_RINGS:   bell_cfg.give_up_rings   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] ct, input logic [15:0] sp,
                            input logic [15:0] lp, input logic [3:0] rpb,
                            input logic [7:0] gu);
    drain();
    write_reg(CFG_COIL_TIME, {8'd0, ct});
    write_reg(CFG_SHORT_PAUSE, sp);
    write_reg(CFG_LONG_PAUSE, lp);
    write_reg(CFG_RINGS_PER_BURST, {12'd0, rpb});
    write_reg(CFG_GIVE_UP_RINGS, {8'd0, gu});
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // mode changes under the reset settings
  task automatic test_handset_and_start();
    send_item(req(FUNC_TICK, 1'b0));      // tick while idle does nothing
    send_item(req(FUNC_UNUSED, 1'b1));    // unused code only reports state
    send_item(req(FUNC_HANDSET, 1'b1));   // replaced while not playing
    send_item(req(FUNC_HANDSET, 1'b0));   // lifted: play starts
    send_item(req(FUNC_HANDSET, 1'b0));   // lifted again while playing
    send_item(req(FUNC_TICK, 1'b1));      // tick while playing
    send_item(req(FUNC_START, 1'b1));     // start overrides playing
    send_item(req(FUNC_TICK, 1'b0));
    send_item(req(FUNC_START, 1'b0));     // start while ringing keeps the step
    send_item(req(FUNC_UNUSED, 1'b0));
    send_item(req(FUNC_HANDSET, 1'b0));   // lift stops ringing at once
    send_item(req(FUNC_HANDSET, 1'b1));   // replaced: back to idle
  endtask

  // one-tick coil steps, no pauses, give up after the first ring
  task automatic test_instant_give_up();
    set_config(8'd0, 16'd0, 16'd0, 4'd1, 8'd0);
    send_item(req(FUNC_START, 1'b0));
    repeat (4) send_item(req(FUNC_TICK, 1'b0));
    send_item(req(FUNC_TICK, 1'b1));
  endtask

  task automatic test_cadence(input logic [7:0] ct, input logic [15:0] sp,
                              input logic [15:0] lp, input logic [3:0] rpb,
                              input logic [7:0] gu, input int n_items);
    set_config(ct, sp, lp, rpb, gu);
    send_item(req(FUNC_START, 1'b0));
    repeat (n_items) send_item(pick_request());
  endtask

  // hold the result side off while requests keep coming, so the input backs up
  task automatic test_stalled_output();
    set_config(8'd1, 16'd2, 16'd1, 4'd2, 8'd6);
    stall_len = STALL_CYCLES;
    repeat (60) send_item(pick_request());
  endtask

  // widest register values: long coil steps, longest pauses, biggest bursts
  task automatic test_extreme_settings();
    set_config(8'd255, 16'hFFFF, 16'hFFFF, 4'd15, 8'd255);
    send_item(req(FUNC_START, 1'b0));
    repeat (80) send_item(req(FUNC_TICK, 1'($urandom_range(1))));
  endtask

  initial begin
    bell_cfg = '{coil_time: COIL_TIME_RST, short_pause: SHORT_PAUSE_RST,
                 long_pause: LONG_PAUSE_RST, rings_per_burst: RINGS_PER_BURST_RST,
                 give_up_rings: GIVE_UP_RINGS_RST};
    bell_st  = '{mode: MODE_IDLE, ring_step: STEP_C1_ON, step_ticks: 16'd0,
                 rings_in_burst: 4'd0, long_pause_next: 1'b1, rings_total: 8'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles often, receiver even more
    send_idle_pct = 35;
    recv_idle_pct = 62;
    test_handset_and_start();
    test_instant_give_up();
    test_cadence(8'd1, 16'd1, 16'd2, 4'd1, 8'd3, 250);
    // zero coil time, burst count wraps at 16, high give-up limit
    test_cadence(8'd0, 16'd3, 16'd0, 4'd0, 8'd255, 200);

    // roles swapped
    send_idle_pct = 62;
    recv_idle_pct = 35;
    test_cadence(8'd2, 16'd0, 16'd3, 4'd2, 8'd5, 250);
    test_cadence(8'($urandom_range(1, 4)), 16'($urandom_range(0, 6)),
                 16'($urandom_range(0, 6)), 4'($urandom_range(1, 4)),
                 8'($urandom_range(0, 12)), 250);
    test_stalled_output();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_extreme_settings();
    test_cadence(8'($urandom_range(1, 3)), 16'($urandom_range(0, 4)),
                 16'($urandom_range(0, 4)), 4'($urandom_range(1, 3)),
                 8'($urandom_range(0, 8)), 250);
    test_cadence(8'd1, 16'd0, 16'd0, 4'd3, 8'($urandom_range(2, 10)), 300);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/brcs_pkg.sv
hw/rtl/brcs_cfg_regs.sv
hw/rtl/brcs_next_state.sv
hw/rtl/bell_ring_cadence_sequencer_core.sv
sim/tb_top.sv
